>>> rtl/dbt_pkg.sv
package dbt_pkg;

   // Input operation codes carried in req_tuser.
   typedef logic [1:0] op_type;
   localparam op_type OP_PIXEL = 2'd0;
   localparam op_type OP_TICK  = 2'd1;
   localparam op_type OP_ALT   = 2'd2;

   // Tracking mode reported with each result.
   typedef logic [1:0] mode_type;
   localparam mode_type MODE_TRACK  = 2'd0;
   localparam mode_type MODE_HOLD   = 2'd1;
   localparam mode_type MODE_SEARCH = 2'd2;

   // Register indexes; register i sits at byte address 4*i.
   typedef logic [2:0] reg_idx_type;
   localparam reg_idx_type REG_ENABLE   = 3'd0;
   localparam reg_idx_type REG_DARK_MAX = 3'd1;
   localparam reg_idx_type REG_HOVER    = 3'd2;
   localparam reg_idx_type REG_BAND     = 3'd3;
   localparam reg_idx_type REG_CLIMB    = 3'd4;
   localparam reg_idx_type REG_TIMEOUT  = 3'd5;
   localparam reg_idx_type REG_MARGIN   = 3'd6;

   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;

   // Register reset values.
   localparam logic [7:0]  DARK_MAX_RST = 8'd50;
   localparam logic [14:0] HOVER_RST    = 15'd4000;
   localparam logic [14:0] BAND_RST     = 15'd500;
   localparam logic [14:0] CLIMB_RST    = 15'd100;
   localparam logic [15:0] TIMEOUT_RST  = 16'd100;
   localparam logic [14:0] MARGIN_RST   = 15'd1000;

   // Descent speed is (altitude - hover) * climb / 1000. The divide is a
   // multiply by ceil(2^41 / 1000), exact for every 31-bit product.
   localparam int unsigned  DESC_SHIFT = 41;
   localparam logic [31:0]  DESC_RECIP = 32'(((64'd1 << DESC_SHIFT) + 64'd999) / 64'd1000);
   // Cycles from a new altitude or register value to a settled descent speed.
   localparam logic [1:0]   DESC_LAT   = 2'd2;

   // Q15 full scale magnitude.
   localparam logic [14:0] Q15_MAX = 15'h7FFF;

endpackage

>>> rtl/dbt_plane_speed.sv
module dbt_plane_speed #(
   parameter int unsigned CENTRE = 240,
   parameter int unsigned POS_W  = 9
) (
   input  logic [POS_W-1:0] pos,
   output logic signed [15:0] speed
);
   import dbt_pkg::*;

   // Offset width: large enough for the centre itself and for any position.
   localparam int unsigned CW   = $clog2(CENTRE + 1);
   localparam int unsigned DW   = (POS_W > CW) ? POS_W : CW;
   // Reciprocal of the centre, exact for offsets below the centre.
   localparam int unsigned LG   = $clog2(CENTRE);
   localparam int unsigned KS   = 27 + LG;
   localparam int unsigned MW   = 29;
   localparam logic [MW-1:0] RECIP =
      MW'(((64'd1 << KS) + 64'(CENTRE) - 64'd1) / 64'(CENTRE));
   localparam logic [DW-1:0] CENTRE_D = DW'(CENTRE);

   logic [DW-1:0]    pos_d;
   logic             below;
   logic [DW-1:0]    offset;
   logic [CW+MW-1:0] prod;
   logic [14:0]      mag;

   always_comb begin
      pos_d  = DW'(pos);
      below  = pos_d < CENTRE_D;
      offset = below ? (CENTRE_D - pos_d) : (pos_d - CENTRE_D);
      // Only used when the offset is below the centre, so CW bits hold it.
      prod   = (CW+MW)'(offset[CW-1:0]) * (CW+MW)'(RECIP);
      if (offset >= CENTRE_D) begin
         mag = Q15_MAX;
      end else begin
         mag = 15'(prod >> (KS - 15));
      end
      speed = below ? $signed({1'b0, mag}) : -$signed({1'b0, mag});
   end

endmodule

>>> rtl/dbt_descent.sv
module dbt_descent (
   input  logic               clock,
   input  logic [15:0]        altitude,
   input  logic [14:0]        hover,
   input  logic [14:0]        climb,
   output logic signed [15:0] vz_desc
);
   import dbt_pkg::*;

   logic [15:0] diff;
   logic [30:0] prod_in, prod_ff;
   logic [62:0] quot_full;
   logic [21:0] quot;
   logic [15:0] vz_in, vz_ff;

   // The difference is only meaningful when altitude is above hover, which
   // is the only case in which the result is used.
   always_comb begin
      diff      = altitude - {1'b0, hover};
      prod_in   = 31'(diff) * 31'(climb);
      quot_full = 63'(prod_ff) * 63'(DESC_RECIP);
      quot      = 22'(quot_full >> DESC_SHIFT);
      if (quot >= 22'd32768) begin
         vz_in = 16'h8000;
      end else begin
         vz_in = 16'd0 - quot[15:0];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      vz_ff   <= vz_in;
   end

   assign vz_desc = $signed(vz_ff);

endmodule

>>> rtl/dark_blob_tracking_velocity_ctrl_unit.sv
// Channel   Dir  Ports                          Word contents
// req       in   req_tvalid/tready/tdata/tlast  pixel, tick or altitude word
//                /tuser                         (tuser = op, tlast = frame end)
// rsp       out  rsp_tvalid/tready/tdata/tuser  one velocity word per frame while enabled
// csr       in   APB psel/penable/pwrite/paddr  seven control registers
//
// One word per cycle: an input register feeds one pass of logic into the
// result register. Pixel, tick and altitude words never stall while a result
// waits. A frame-end word, while enabled, waits for a free result register
// and, after an altitude word or a register write, while the registered
// descent multiplier settles. Reset is synchronous, no clearing pass.
module dark_blob_tracking_velocity_ctrl_unit #(
   parameter int unsigned FRAME_ROWS = 480,
   parameter int unsigned FRAME_COLS = 640
) (
   input  logic                            clock,
   input  logic                            reset,
   // Fields from bit 0: pixel_value[7:0], pixel_row[16:8], pixel_col[26:17],
   // altitude_mm[42:27], zero fill[47:43].
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [47:0]                     req_tdata,
   input  logic                            req_tlast,
   // Fields from bit 0: op[1:0].
   input  logic [1:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // Fields from bit 0: vel_x[15:0], vel_y[31:16], vel_z[47:32].
   output logic [47:0]                     rsp_tdata,
   // Fields from bit 0: target_seen[0], track_mode[2:1].
   output logic [2:0]                      rsp_tuser,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [dbt_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [dbt_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [dbt_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import dbt_pkg::*;

   localparam int unsigned ROW_CENTRE = FRAME_ROWS / 2;
   localparam int unsigned COL_CENTRE = FRAME_COLS / 2;

   // Control registers.
   logic        enable_ff;
   logic [7:0]  dark_max_ff;
   logic [14:0] hover_ff, band_ff, climb_ff, margin_ff;
   logic [15:0] timeout_ff;
   logic        csr_wr;
   reg_idx_type csr_idx;

   // Input register.
   logic        s1_valid_ff;
   op_type      s1_op_ff;
   logic [7:0]  s1_value_ff;
   logic [8:0]  s1_row_ff;
   logic [9:0]  s1_col_ff;
   logic        s1_last_ff;
   logic [15:0] s1_alt_ff;

   // Tracker state.
   logic        found_ff, found_in;
   logic [8:0]  found_row_ff;
   logic [9:0]  found_col_ff;
   logic [15:0] ticks_ff, ticks_in;
   logic [15:0] alt_ff;
   logic [15:0] held_vz_ff;
   logic [1:0]  busy_ff, busy_in;

   // Result register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [47:0] rsp_data_ff;
   logic [2:0]  rsp_user_ff;

   logic              out_free, s1_result, s1_go;
   logic              hit, eff_found;
   logic [8:0]        eff_row;
   logic [9:0]        eff_col;
   logic signed [15:0] vx, vy, vz_desc;
   logic [15:0]       vz;
   mode_type          mode;
   logic signed [17:0] alt_s, h_lo, h_hi, s_lo, s_hi;
   logic [15:0]       climb_pos, climb_neg;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[4:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff   <= 1'b0;
         dark_max_ff <= DARK_MAX_RST;
         hover_ff    <= HOVER_RST;
         band_ff     <= BAND_RST;
         climb_ff    <= CLIMB_RST;
         timeout_ff  <= TIMEOUT_RST;
         margin_ff   <= MARGIN_RST;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_ENABLE:   enable_ff   <= csr_pwdata[0];
            REG_DARK_MAX: dark_max_ff <= csr_pwdata[7:0];
            REG_HOVER:    hover_ff    <= csr_pwdata[14:0];
            REG_BAND:     band_ff     <= csr_pwdata[14:0];
            REG_CLIMB:    climb_ff    <= csr_pwdata[14:0];
            REG_TIMEOUT:  timeout_ff  <= csr_pwdata[15:0];
            REG_MARGIN:   margin_ff   <= csr_pwdata[14:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_ENABLE:   csr_prdata = 32'(enable_ff);
         REG_DARK_MAX: csr_prdata = 32'(dark_max_ff);
         REG_HOVER:    csr_prdata = 32'(hover_ff);
         REG_BAND:     csr_prdata = 32'(band_ff);
         REG_CLIMB:    csr_prdata = 32'(climb_ff);
         REG_TIMEOUT:  csr_prdata = 32'(timeout_ff);
         REG_MARGIN:   csr_prdata = 32'(margin_ff);
         default:      csr_prdata = 32'd0;
      endcase
   end

   // ---------------- datapath units ----------------
   dbt_plane_speed #(.CENTRE(ROW_CENTRE), .POS_W(9)) u_row_speed (
      .pos   (eff_row),
      .speed (vx)
   );

   dbt_plane_speed #(.CENTRE(COL_CENTRE), .POS_W(10)) u_col_speed (
      .pos   (eff_col),
      .speed (vy)
   );

   dbt_descent u_descent (
      .clock    (clock),
      .altitude (alt_ff),
      .hover    (hover_ff),
      .climb    (climb_ff),
      .vz_desc  (vz_desc)
   );

   // ---------------- flow control ----------------
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_result  = (s1_op_ff == OP_PIXEL) && enable_ff && s1_last_ff;
   assign s1_go      = s1_valid_ff && !(s1_result && (!out_free || (busy_ff != 2'd0)));
   assign req_tready = !s1_valid_ff || s1_go;

   // ---------------- per-word logic ----------------
   always_comb begin
      hit       = !found_ff && (s1_value_ff <= dark_max_ff);
      eff_found = found_ff || hit;
      eff_row   = found_ff ? found_row_ff : s1_row_ff;
      eff_col   = found_ff ? found_col_ff : s1_col_ff;

      alt_s     = $signed({2'b00, alt_ff});
      h_lo      = $signed({3'b000, hover_ff}) - $signed({3'b000, band_ff});
      h_hi      = $signed({3'b000, hover_ff}) + $signed({3'b000, band_ff});
      s_lo      = $signed({2'b00, hover_ff, 1'b0}) - $signed({3'b000, margin_ff});
      s_hi      = $signed({2'b00, hover_ff, 1'b0}) + $signed({3'b000, margin_ff});
      climb_pos = {1'b0, climb_ff};
      climb_neg = 16'd0 - climb_pos;

      if (eff_found) begin
         mode = MODE_TRACK;
         if (alt_s < h_lo) begin
            vz = climb_pos;
         end else if (alt_s < h_hi) begin
            vz = 16'd0;
         end else begin
            vz = vz_desc;
         end
      end else if (ticks_ff < timeout_ff) begin
         mode = MODE_HOLD;
         vz   = held_vz_ff;
      end else begin
         mode = MODE_SEARCH;
         if (alt_s < s_lo) begin
            vz = climb_pos;
         end else if (alt_s > s_hi) begin
            vz = climb_neg;
         end else begin
            vz = 16'd0;
         end
      end

      found_in = found_ff;
      ticks_in = ticks_ff;
      if (s1_go) begin
         case (s1_op_ff)
            OP_TICK: begin
               if (ticks_ff != 16'hFFFF) begin
                  ticks_in = ticks_ff + 16'd1;
               end
            end
            OP_PIXEL: begin
               if (!enable_ff) begin
                  if (s1_last_ff) begin
                     found_in = 1'b0;
                  end
               end else if (s1_last_ff) begin
                  found_in = 1'b0;
                  if (eff_found) begin
                     ticks_in = 16'd0;
                  end
               end else if (hit) begin
                  found_in = 1'b1;
               end
            end
            default: ;
         endcase
      end

      busy_in = (busy_ff != 2'd0) ? (busy_ff - 2'd1) : 2'd0;
      if (csr_wr || (s1_go && (s1_op_ff == OP_ALT))) begin
         busy_in = DESC_LAT;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (s1_go && s1_result) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         found_ff     <= 1'b0;
         ticks_ff     <= 16'd0;
         alt_ff       <= 16'd0;
         held_vz_ff   <= 16'd0;
         busy_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            s1_valid_ff <= req_tvalid;
         end
         found_ff     <= found_in;
         ticks_ff     <= ticks_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_go && (s1_op_ff == OP_ALT)) begin
            alt_ff <= s1_alt_ff;
         end
         if (s1_go && s1_result) begin
            held_vz_ff <= vz;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_op_ff    <= req_tuser;
         s1_value_ff <= req_tdata[7:0];
         s1_row_ff   <= req_tdata[16:8];
         s1_col_ff   <= req_tdata[26:17];
         s1_alt_ff   <= req_tdata[42:27];
         s1_last_ff  <= req_tlast;
      end
      if (s1_go && (s1_op_ff == OP_PIXEL) && enable_ff && !s1_last_ff && hit) begin
         found_row_ff <= s1_row_ff;
         found_col_ff <= s1_col_ff;
      end
      if (s1_go && s1_result) begin
         if (eff_found) begin
            rsp_data_ff <= {vz, vy, vx};
         end else begin
            rsp_data_ff <= {vz, 32'd0};
         end
         rsp_user_ff <= {mode, eff_found};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef SYNTHESIS
   // A result reports a target exactly when it is in tracking mode.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser[0] == (rsp_tuser[2:1] == MODE_TRACK)))
      else $error("target flag and tracking mode disagree");

   // Without a target the planar speeds are zero.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata[31:0] == 32'd0))
      else $error("planar speed set without a target");

   // A tick below saturation advances the lost counter by exactly one.
   assert property (@(posedge clock) disable iff (reset)
      (s1_go && (s1_op_ff == OP_TICK) && (ticks_ff != 16'hFFFF))
      |=> (ticks_ff == $past(ticks_ff) + 16'd1))
      else $error("tick counter did not advance");

   // A frame-end word does not complete straight after an altitude word, while the descent speed is settling.
   assert property (@(posedge clock) disable iff (reset)
      (s1_go && (s1_op_ff == OP_ALT)) |=> !(s1_go && s1_result))
      else $error("result computed from a stale descent speed");
`endif

endmodule
